>>> rtl/ots_pkg.sv
// ----------------------------------------------------------------------------
// ots_pkg
// shared types and constants for the one-shot timer bank
// ----------------------------------------------------------------------------
package ots_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int TIMER_W        = 16;

    // command codes, codes ten and up behave as read
    typedef enum logic [3:0] {
        OP_TICK          = 4'd0,
        OP_CREATE        = 4'd1,
        OP_DELETE        = 4'd2,
        OP_START         = 4'd3,
        OP_RESTART       = 4'd4,
        OP_STOP          = 4'd5,
        OP_CLEAR_COUNT   = 4'd6,
        OP_SET_TIME      = 4'd7,
        OP_CLEAR_TIMEOUT = 4'd8,
        OP_READ          = 4'd9
    } t_opcode;

    typedef struct packed {
        logic [3:0]         opcode;
        logic [3:0]         timer_index;
        logic [TIMER_W-1:0] time_value;
        logic               reload_mode;
    } t_in;

    typedef struct packed {
        logic               status;
        logic [TIMER_W-1:0] timer_time;
        logic [TIMER_W-1:0] timer_count;
        logic               timed_out;
        logic [TIMER_W-1:0] expired_mask;
    } t_out;

    // one timer memory word
    typedef struct packed {
        logic [TIMER_W-1:0] period;
        logic [TIMER_W-1:0] count;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_DRAIN,
        S_READ,
        S_MOD
    } t_state;

endpackage

>>> rtl/one_shot_timer_bank.sv
// ----------------------------------------------------------------------------
// one_shot_timer_bank
// sequence: a command is taken in idle, its entry is read in read and the result
//   is registered in mod; a tick first walks the timer memory one entry a cycle
//   and drains the last write-back; mod waits while the output register is full
// throughput: one item at a time, the next transfer is taken the cycle after
//   the result enters the output register
// reset: synchronous active low, all timers free, stopped, period and count
//   read as zero through per-entry valid bits
// ----------------------------------------------------------------------------
module one_shot_timer_bank #(
    parameter int NUM_TIMERS = ots_pkg::NUM_TIMERS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ots_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output ots_pkg::t_out o_out
);
    import ots_pkg::*;

    localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam logic [AW-1:0] LAST = AW'(NUM_TIMERS - 1);

    // control
    t_state r_state, n_state;
    t_in    r_cmd;
    logic   r_idx_ok;
    logic [AW-1:0] r_addr, n_addr;

    // walk pipeline: entry whose read data arrives this cycle
    logic          r_wk_vld, n_wk_vld;
    logic [AW-1:0] r_wk_idx, n_wk_idx;

    // per-timer flag vectors
    logic [NUM_TIMERS-1:0] r_alloc, n_alloc;
    logic [NUM_TIMERS-1:0] r_run, n_run;
    logic [NUM_TIMERS-1:0] r_tmo, n_tmo;
    logic [NUM_TIMERS-1:0] r_valid;
    logic [NUM_TIMERS-1:0] r_expired, n_expired;

    // timer memory, one read and one write port
    t_entry        r_mem [NUM_TIMERS];
    t_entry        r_rd_data;
    logic          r_rd_hit;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    t_entry        wr_data;
    t_entry        rd_ent;

    // output register
    logic r_out_vld, n_out_vld;
    t_out r_out, n_out;

    logic          in_xfer;
    logic          out_free;
    logic [AW-1:0] cmd_addr;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_vld || i_out_ready;
    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;
    assign cmd_addr    = AW'(r_cmd.timer_index);

    // entries never written read as zero
    assign rd_ent = r_rd_hit ? r_rd_data : '0;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_state = (t_opcode'(i_in.opcode) == OP_TICK) ? S_WALK : S_READ;
                end
            end
            S_WALK: begin
                if (r_addr == LAST) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_READ;
            S_READ:  n_state = S_MOD;
            S_MOD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        t_entry             ent;
        logic [TIMER_W-1:0] inc;
        logic               st;
        logic               tmo_now;

        rd_en     = 1'b0;
        rd_addr   = r_addr;
        wr_en     = 1'b0;
        wr_addr   = r_wk_idx;
        wr_data   = rd_ent;
        n_alloc   = r_alloc;
        n_run     = r_run;
        n_tmo     = r_tmo;
        n_expired = r_expired;
        n_addr    = r_addr;
        n_wk_vld  = 1'b0;
        n_wk_idx  = r_addr;
        n_out_vld = r_out_vld && !i_out_ready;
        n_out     = r_out;
        ent       = rd_ent;
        inc       = '0;
        st        = 1'b0;
        tmo_now   = 1'b0;

        // tick update of the entry read in the previous cycle
        if (r_wk_vld && r_alloc[r_wk_idx] && r_run[r_wk_idx]) begin
            inc = rd_ent.count + TIMER_W'(1);
            if (inc == rd_ent.period) begin
                n_tmo[r_wk_idx]     = 1'b1;
                n_run[r_wk_idx]     = 1'b0;
                n_expired[r_wk_idx] = 1'b1;
                inc                 = '0;
            end
            wr_en   = 1'b1;
            wr_addr = r_wk_idx;
            wr_data = '{period: rd_ent.period, count: inc};
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_addr    = '0;
                    n_expired = '0;
                end
            end
            S_WALK: begin
                // read entry k while entry k-1 is written back
                rd_en    = 1'b1;
                rd_addr  = r_addr;
                n_wk_vld = 1'b1;
                n_wk_idx = r_addr;
                if (r_addr != LAST) begin
                    n_addr = r_addr + AW'(1);
                end
            end
            S_DRAIN: begin
            end
            S_READ: begin
                rd_en   = r_idx_ok;
                rd_addr = cmd_addr;
            end
            S_MOD: begin
                if (out_free) begin
                    n_out_vld = 1'b1;
                    if (r_idx_ok) begin
                        tmo_now = r_tmo[cmd_addr];
                        unique case (t_opcode'(r_cmd.opcode))
                            OP_CREATE: begin
                                if (r_alloc[cmd_addr]) begin
                                    st = 1'b1;
                                end else begin
                                    ent.period        = r_cmd.time_value;
                                    ent.count         = '0;
                                    wr_en             = 1'b1;
                                    n_alloc[cmd_addr] = 1'b1;
                                    n_run[cmd_addr]   = 1'b0;
                                    n_tmo[cmd_addr]   = 1'b0;
                                    tmo_now           = 1'b0;
                                end
                            end
                            OP_DELETE: begin
                                if (!r_alloc[cmd_addr]) begin
                                    st = 1'b1;
                                end else begin
                                    n_alloc[cmd_addr] = 1'b0;
                                    n_run[cmd_addr]   = 1'b0;
                                    n_tmo[cmd_addr]   = 1'b0;
                                    tmo_now           = 1'b0;
                                end
                            end
                            OP_START: n_run[cmd_addr] = 1'b1;
                            OP_RESTART: begin
                                n_tmo[cmd_addr] = 1'b0;
                                n_run[cmd_addr] = 1'b1;
                                tmo_now         = 1'b0;
                            end
                            OP_STOP: n_run[cmd_addr] = 1'b0;
                            OP_CLEAR_COUNT: begin
                                ent.count = '0;
                                wr_en     = 1'b1;
                            end
                            OP_SET_TIME: begin
                                ent.period = r_cmd.time_value;
                                wr_en      = 1'b1;
                            end
                            OP_CLEAR_TIMEOUT: begin
                                n_tmo[cmd_addr] = 1'b0;
                                tmo_now         = 1'b0;
                            end
                            default: begin
                            end
                        endcase
                        wr_addr = cmd_addr;
                        wr_data = ent;
                    end else if (t_opcode'(r_cmd.opcode) == OP_CREATE ||
                                 t_opcode'(r_cmd.opcode) == OP_DELETE) begin
                        st = 1'b1;
                    end
                    n_out.status       = st;
                    n_out.timer_time   = r_idx_ok ? ent.period : '0;
                    n_out.timer_count  = r_idx_ok ? ent.count : '0;
                    n_out.timed_out    = r_idx_ok && tmo_now;
                    n_out.expired_mask = (t_opcode'(r_cmd.opcode) == OP_TICK) ?
                                         TIMER_W'(r_expired) : '0;
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_alloc   <= '0;
            r_run     <= '0;
            r_tmo     <= '0;
            r_valid   <= '0;
            r_wk_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_alloc   <= n_alloc;
            r_run     <= n_run;
            r_tmo     <= n_tmo;
            r_wk_vld  <= n_wk_vld;
            r_out_vld <= n_out_vld;
            if (wr_en) begin
                r_valid[wr_addr] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd    <= i_in;
            r_idx_ok <= (int'(i_in.timer_index) < NUM_TIMERS);
        end
        r_addr    <= n_addr;
        r_wk_idx  <= n_wk_idx;
        r_expired <= n_expired;
        r_out     <= n_out;
    end

    // timer memory
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_hit  <= r_valid[rd_addr];
        end
    end

endmodule

>>> rtl/ots_checker.sv
// ----------------------------------------------------------------------------
// ots_checker
// port level checks for the one-shot timer bank
// ----------------------------------------------------------------------------
module ots_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input ots_pkg::t_out o_out
);
    import ots_pkg::*;

    // a waiting result holds until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed before transfer");

    // one item at a time: no transfer right after a transfer
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while busy");

    // error status and expiry mask never together: status is set only for create or delete, the mask only for tick
    a_status_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status |-> o_out.expired_mask == '0)
        else $error("error status with expiry mask");

    // no result right after reset
    a_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind one_shot_timer_bank ots_checker u_ots_checker (.*);
